// ===== rtl/core/fpwt_pkg.sv =====
// Shared types and constants for the four-level page table walker.
package fpwt_pkg;

  localparam int ADDR_W = 64;
  localparam int IDX_W = 9;
  localparam int OFF_W = 12;
  localparam int ENTRY_SH = 3;
  localparam int CFG_IDX_W = 2;

  localparam int LEVELS_DEF = 4;

  localparam logic [ADDR_W-1:0] PHYS_MASK_RST = 64'h000f_ffff_ffff_ffff;
  localparam logic [ADDR_W-1:0] ENTRY_MASK_RST = 64'hffff_ffff_ffff_f000;
  localparam logic [ADDR_W-1:0] RESULT_BASE_RST = 64'h0;

  // Input item kinds
  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_BASE = 2'd2;

  typedef enum logic [1:0] {
    ST_READ  = 2'd0,
    ST_DONE  = 2'd1,
    ST_FAULT = 2'd2
  } status_e;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [ADDR_W-1:0] address;
  } result_t;

endpackage

// ===== rtl/core/fpwt_step.sv =====
// Walk step logic: next walk state and result for one transaction.
module fpwt_step #(
  parameter int LEVELS = fpwt_pkg::LEVELS_DEF,
  parameter int LVL_W = $clog2(LEVELS)
) (
  input  logic                      kind_i,
  input  logic [fpwt_pkg::ADDR_W-1:0] root_i,
  input  logic [fpwt_pkg::ADDR_W-1:0] addr_i,
  input  logic [fpwt_pkg::ADDR_W-1:0] read_data_i,
  input  logic                      walking_i,
  input  logic [LVL_W-1:0]          level_i,
  input  logic [fpwt_pkg::ADDR_W-1:0] held_i,
  input  logic [fpwt_pkg::ADDR_W-1:0] phys_mask_i,
  input  logic [fpwt_pkg::ADDR_W-1:0] entry_mask_i,
  input  logic [fpwt_pkg::ADDR_W-1:0] result_base_i,
  output logic                      walking_d_o,
  output logic [LVL_W-1:0]          level_d_o,
  output logic [fpwt_pkg::ADDR_W-1:0] held_d_o,
  output fpwt_pkg::result_t         res_o
);

  localparam int AW = fpwt_pkg::ADDR_W;
  localparam int IW = fpwt_pkg::IDX_W;
  localparam int OW = fpwt_pkg::OFF_W;
  localparam int ESH = fpwt_pkg::ENTRY_SH;
  localparam int SH_ROOT = OW + IW * (LEVELS - 1);
  localparam int NLVL = 2 ** LVL_W;

  logic [NLVL-1:0][IW-1:0] held_idx;
  logic [AW-1:0]           req_held;
  logic [AW-1:0]           req_base;
  logic [AW-1:0]           entry;
  logic [LVL_W-1:0]        next_lvl;
  logic                    last_lvl;

  // Table index of each level of the held address; root table is level 0
  for (genvar k = 0; k < NLVL; k++) begin : g_idx
    if (k < LEVELS) begin : g_used
      localparam int SH = OW + IW * (LEVELS - 1 - k);
      assign held_idx[k] = held_i[SH +: IW];
    end else begin : g_pad
      assign held_idx[k] = '0;
    end
  end

  assign req_held = addr_i & phys_mask_i;
  assign req_base = root_i & phys_mask_i & entry_mask_i;
  assign entry = read_data_i & phys_mask_i & entry_mask_i;
  assign next_lvl = level_i + LVL_W'(1);
  assign last_lvl = (level_i == LVL_W'(LEVELS - 1));

  always_comb begin
    walking_d_o = walking_i;
    level_d_o = level_i;
    held_d_o = held_i;
    res_o.valid = 1'b0;
    res_o.status = fpwt_pkg::ST_READ;
    res_o.address = '0;
    if (kind_i == fpwt_pkg::KIND_REQ) begin
      // a new request drops any walk in flight
      walking_d_o = 1'b1;
      level_d_o = '0;
      held_d_o = req_held;
      res_o.valid = 1'b1;
      res_o.status = fpwt_pkg::ST_READ;
      res_o.address = req_base
          + {{(AW-IW-ESH){1'b0}}, req_held[SH_ROOT +: IW], {ESH{1'b0}}};
    end else if (walking_i) begin
      res_o.valid = 1'b1;
      if (entry == '0) begin
        walking_d_o = 1'b0;
        level_d_o = '0;
        res_o.status = fpwt_pkg::ST_FAULT;
        res_o.address = '1;
      end else if (last_lvl) begin
        walking_d_o = 1'b0;
        level_d_o = '0;
        res_o.status = fpwt_pkg::ST_DONE;
        res_o.address = entry + {{(AW-OW){1'b0}}, held_i[OW-1:0]} + result_base_i;
      end else begin
        level_d_o = next_lvl;
        res_o.status = fpwt_pkg::ST_READ;
        res_o.address = entry
            + {{(AW-IW-ESH){1'b0}}, held_idx[next_lvl], {ESH{1'b0}}};
      end
    end
  end

endmodule

// ===== rtl/core/four_level_page_walk_translate_core.sv =====
// Page table walker top level: input stage, walk state, result register, config.
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i/in_ready_o   kind_i root_i addr_i read_data_i
//  out       source     out_valid_o/out_ready_i status_o address_o
//  cfg       sink       cfg_we_i                cfg_idx_i cfg_wdata_i
//
// One transaction per cycle while the result is not stalled; a result passes the input
// register, then the result register behind the step logic, on its way to the outputs.
// The walk state (walking, level, held address) updates as the input stage drains.
// Read data while idle leaves no result. Reset clears all valid and walk state
// and loads the register defaults. A stalled result holds the input stage, and
// the input stage takes a new transaction in the cycle it drains.
module four_level_page_walk_translate_core #(
  parameter int LEVELS = fpwt_pkg::LEVELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fpwt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fpwt_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [fpwt_pkg::ADDR_W-1:0]   root_i,
  input  logic [fpwt_pkg::ADDR_W-1:0]   addr_i,
  input  logic [fpwt_pkg::ADDR_W-1:0]   read_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [fpwt_pkg::ADDR_W-1:0]   address_o
);

  localparam int AW = fpwt_pkg::ADDR_W;
  localparam int LVL_W = $clog2(LEVELS);

  logic [AW-1:0]      phys_mask_q, entry_mask_q, result_base_q;

  logic               s1_valid_q;
  logic               s1_kind_q;
  logic [AW-1:0]      s1_root_q, s1_addr_q, s1_data_q;

  logic               walking_q, walking_d;
  logic [LVL_W-1:0]   level_q, level_d;
  logic [AW-1:0]      held_q, held_d;

  logic               out_valid_q;
  fpwt_pkg::status_e  status_q;
  logic [AW-1:0]      address_q;

  fpwt_pkg::result_t  res;
  logic               adv;
  logic               in_acc;

  assign adv = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign in_acc = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phys_mask_q <= fpwt_pkg::PHYS_MASK_RST;
      entry_mask_q <= fpwt_pkg::ENTRY_MASK_RST;
      result_base_q <= fpwt_pkg::RESULT_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpwt_pkg::CFG_PHYS_MASK: phys_mask_q <= cfg_wdata_i;
        fpwt_pkg::CFG_ENTRY_MASK: entry_mask_q <= cfg_wdata_i;
        fpwt_pkg::CFG_RESULT_BASE: result_base_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= kind_i;
      s1_root_q <= root_i;
      s1_addr_q <= addr_i;
      s1_data_q <= read_data_i;
    end
  end

  fpwt_step #(
    .LEVELS(LEVELS),
    .LVL_W (LVL_W)
  ) u_step (
    .kind_i       (s1_kind_q),
    .root_i       (s1_root_q),
    .addr_i       (s1_addr_q),
    .read_data_i  (s1_data_q),
    .walking_i    (walking_q),
    .level_i      (level_q),
    .held_i       (held_q),
    .phys_mask_i  (phys_mask_q),
    .entry_mask_i (entry_mask_q),
    .result_base_i(result_base_q),
    .walking_d_o  (walking_d),
    .level_d_o    (level_d),
    .held_d_o     (held_d),
    .res_o        (res)
  );

  // Walk state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walking_q <= 1'b0;
      level_q <= '0;
      held_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      walking_q <= walking_d;
      level_q <= level_d;
      held_q <= held_d;
      out_valid_q <= res.valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      status_q <= res.status;
      address_q <= res.address;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign address_o = address_q;

  a_idle_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !walking_q |-> level_q == '0)
    else $error("level nonzero while idle");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_W'(LEVELS - 1))
    else $error("level beyond last table");

  a_req_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s1_kind_q == fpwt_pkg::KIND_REQ |=> walking_q && level_q == '0)
    else $error("request did not restart walk");

  a_end_stops_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res.valid && res.status != fpwt_pkg::ST_READ |=> !walking_q)
    else $error("walk still active after final result");

  a_fault_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == fpwt_pkg::ST_FAULT |-> &address_q)
    else $error("fault result without all-ones address");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q)
    else $error("input stage lost a stalled transaction");

endmodule

// ===== verif/tb_four_level_page_walk_translate_core.sv =====
// Self-checking testbench for the four-level page table walker core.
module tb_four_level_page_walk_translate_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fpwt_pkg::*;

  localparam int LEVELS = LEVELS_DEF;
  localparam int MAX_GAP = 18;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    status_e           status;
    logic [ADDR_W-1:0] address;
  } walk_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_PHYS_MASK;
  logic [ADDR_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 kind_i = KIND_REQ;
  logic [ADDR_W-1:0]    root_i = '0;
  logic [ADDR_W-1:0]    addr_i = '0;
  logic [ADDR_W-1:0]    read_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [1:0]           status_o;
  logic [ADDR_W-1:0]    address_o;

  four_level_page_walk_translate_core #(.LEVELS(LEVELS)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .root_i      (root_i),
    .addr_i      (addr_i),
    .read_data_i (read_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .address_o   (address_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walker model state and register copies
  logic [ADDR_W-1:0] phys_mask_q = PHYS_MASK_RST;
  logic [ADDR_W-1:0] entry_mask_q = ENTRY_MASK_RST;
  logic [ADDR_W-1:0] result_base_q = RESULT_BASE_RST;
  bit                walk_active = 1'b0;
  int unsigned       walk_level = 0;
  logic [ADDR_W-1:0] walk_vaddr = '0;

  walk_result_t expected_walk_q[$];

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_req = 1'b0;

  int mismatch_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int reads_seen = 0;
  int done_seen = 0;
  int faults_seen = 0;
  int cfg_writes = 0;

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [ADDR_W-1:0] table_offset(int unsigned k);
    int unsigned sh;
    sh = OFF_W + IDX_W * (LEVELS - 1 - k);
    if (sh > ADDR_W - 1) return '0;
    return ((walk_vaddr >> sh) & 64'h1ff) << ENTRY_SH;
  endfunction

  // Advance the walker model by one transaction; queue the result it causes.
  task automatic predict_walk_step(input logic kind, input logic [ADDR_W-1:0] root,
                                   input logic [ADDR_W-1:0] vaddr,
                                   input logic [ADDR_W-1:0] data);
    walk_result_t      res;
    logic [ADDR_W-1:0] entry;
    if (kind == KIND_REQ) begin
      walk_vaddr  = vaddr & phys_mask_q;
      walk_level  = 0;
      walk_active = 1'b1;
      res.status  = ST_READ;
      res.address = (root & phys_mask_q & entry_mask_q) + table_offset(0);
      expected_walk_q.push_back(res);
    end else if (walk_active) begin
      entry = data & phys_mask_q & entry_mask_q;
      if (entry == '0) begin
        walk_active = 1'b0;
        walk_level  = 0;
        res.status  = ST_FAULT;
        res.address = '1;
      end else begin
        walk_level++;
        if (walk_level >= LEVELS) begin
          walk_active = 1'b0;
          walk_level  = 0;
          res.status  = ST_DONE;
          res.address = entry + (walk_vaddr & 64'hfff) + result_base_q;
        end else begin
          res.status  = ST_READ;
          res.address = entry + table_offset(walk_level);
        end
      end
      expected_walk_q.push_back(res);
    end
  endtask

  // Offer one transaction, hold it until accepted, then update the model.
  task automatic send_item(input logic kind, input logic [ADDR_W-1:0] root,
                           input logic [ADDR_W-1:0] vaddr,
                           input logic [ADDR_W-1:0] data);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i      = kind;
    root_i      = root;
    addr_i      = vaddr;
    read_data_i = data;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    predict_walk_step(kind, root, vaddr, data);
  endtask

  task automatic send_request(input logic [ADDR_W-1:0] root, input logic [ADDR_W-1:0] vaddr);
    send_item(KIND_REQ, root, vaddr, rand64());
  endtask

  task automatic send_entry(input logic [ADDR_W-1:0] data);
    send_item(KIND_DATA, rand64(), rand64(), data);
  endtask

  // Drop valid and wait until every queued result is out and the pipe is empty.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_walk_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ADDR_W-1:0] pmask, input logic [ADDR_W-1:0] emask,
                            input logic [ADDR_W-1:0] rbase);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_PHYS_MASK;
    cfg_wdata_i = pmask;
    @(negedge clk_i);
    cfg_idx_i   = CFG_ENTRY_MASK;
    cfg_wdata_i = emask;
    @(negedge clk_i);
    cfg_idx_i   = CFG_RESULT_BASE;
    cfg_wdata_i = rbase;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    phys_mask_q   = pmask;
    entry_mask_q  = emask;
    result_base_q = rbase;
    cfg_writes += 3;
  endtask

  // Random entry: mostly live, sometimes zero or carrying only masked-out bits.
  function automatic logic [ADDR_W-1:0] pick_entry();
    int sel;
    sel = $urandom_range(0, 11);
    if (sel == 0) return '0;
    if (sel == 1) return rand64() & ~(phys_mask_q & entry_mask_q);
    return rand64();
  endfunction

  // Receiver: per result draw a stall, or take a long hold when asked.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_burst = ~rx_burst;
        n = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      @(negedge clk_i);
      if (n > 0) begin
        out_ready_i = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    walk_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_walk_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("[%0t] unexpected result: status %0d address %h", $realtime,
                   status_o, address_o);
      end else begin
        exp_res = expected_walk_q.pop_front();
        case (exp_res.status)
          ST_READ:  reads_seen++;
          ST_DONE:  done_seen++;
          default:  faults_seen++;
        endcase
        if (status_o !== exp_res.status || address_o !== exp_res.address) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: expected status %0d address %h, got status %0d address %h",
                     $realtime, exp_res.status, exp_res.address, status_o, address_o);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("[%0t] watchdog expired with %0d results outstanding", $realtime,
                 expected_walk_q.size());
        $display("four_level_page_walk_translate_core regression: fail");
        $finish;
      end
    end
  end

  task automatic test_reset_walk();
    send_request('1, '1);
    repeat (LEVELS) send_entry('1);
    send_request(rand64(), rand64());
    repeat (LEVELS) send_entry(64'h0000_0000_0000_1000);
  endtask

  task automatic test_faults();
    send_request(rand64(), rand64());
    send_entry('0);
    send_request(rand64(), rand64());
    repeat (LEVELS - 1) send_entry(rand64() | 64'h1000);
    send_entry(64'hfff0_0000_0000_0fff);
  endtask

  task automatic test_idle_data();
    send_entry(rand64());
    send_entry('1);
  endtask

  task automatic test_abandon();
    send_request(rand64(), rand64());
    send_entry(rand64() | 64'h1000);
    send_request('0, '0);
    repeat (LEVELS) send_entry(rand64() | 64'h1000);
  endtask

  task automatic test_config_extremes();
    set_config('1, '1, '1);
    send_request('1, '1);
    repeat (LEVELS) send_entry('1);
    set_config('0, ENTRY_MASK_RST, RESULT_BASE_RST);
    send_request('1, '1);
    send_entry('1);
    set_config(PHYS_MASK_RST, '0, 64'hffff_8880_0000_0000);
    send_request(rand64(), rand64());
    send_entry('1);
    set_config(PHYS_MASK_RST, ENTRY_MASK_RST, 64'hffff_8880_0000_0000);
    send_request(rand64(), rand64());
    repeat (LEVELS) send_entry(rand64() | 64'h1000);
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering.
  task automatic test_pressure();
    tx_burst = 1'b1;
    hold_req = 1'b1;
    repeat (4) begin
      send_request(rand64(), rand64());
      repeat (LEVELS) send_entry(rand64() | 64'h1000);
    end
    tx_burst = 1'b0;
  endtask

  task automatic test_random(input int n_items);
    int start;
    int n_data;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 7) == 0) tx_burst = ~tx_burst;
      if ($urandom_range(0, 4) != 0) begin
        send_request(rand64(), rand64());
        n_data = ($urandom_range(0, 3) != 0) ? LEVELS : $urandom_range(0, LEVELS + 1);
        repeat (n_data) send_entry(pick_entry());
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(logic'($urandom_range(0, 1)), rand64(), rand64(), rand64());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_walk();
    test_faults();
    test_idle_data();
    test_abandon();
    test_config_extremes();
    test_pressure();

    set_config(PHYS_MASK_RST, ENTRY_MASK_RST, RESULT_BASE_RST);
    test_random(95);
    set_config('1, '1, '1);
    test_random(95);
    set_config(PHYS_MASK_RST, ENTRY_MASK_RST, 64'hffff_8880_0000_0000);
    test_random(95);
    set_config(rand64() | 64'h000f_0000_0000_0000, rand64() | 64'hffff_0000_0000_0000,
               rand64());
    test_random(95);
    set_config(rand64(), rand64(), rand64());
    test_random(95);
    set_config(64'h0000_00ff_ffff_ffff, 64'h7fff_ffff_ffff_f000, rand64());
    test_random(95);

    wait_idle();
    $display("Covered %0d transactions in, %0d results out (%0d reads, %0d done, %0d faults),",
             items_sent, results_seen, reads_seen, done_seen, faults_seen);
    $display("  %0d register writes across ten settings, %0d mismatches.",
             cfg_writes, mismatch_count);
    if (mismatch_count == 0 && expected_walk_q.size() == 0) begin
      $display("four_level_page_walk_translate_core regression: pass");
    end else begin
      $display("four_level_page_walk_translate_core regression: fail");
    end
    $finish;
  end

endmodule
